FILE: rtl/cs_pkg.sv
// ----------------------------------------------------------------------------
// Cosine similarity package
// Item and result types, sum record and field widths shared by the block.
// ----------------------------------------------------------------------------
package cs_pkg;

    localparam int ELEM_W = 16;
    localparam int DOT_W  = 42;
    localparam int SQ_W   = 41;

    // One element pair from the input side
    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_a;
        logic signed [ELEM_W-1:0] elem_b;
        logic                     last;
    } t_item;

    // One finished similarity
    typedef struct packed {
        logic signed [ELEM_W-1:0] similarity;
        logic                     zero_magnitude;
    } t_result;

    // Final sums of one vector pair, handed from front to back
    typedef struct packed {
        logic signed [DOT_W-1:0] dot_sum;
        logic [SQ_W-1:0]         sum_sq_a;
        logic [SQ_W-1:0]         sum_sq_b;
    } t_sums;

endpackage

FILE: rtl/cs_fifo.sv
// ----------------------------------------------------------------------------
// Two-entry queue
// Head and spare register pair; full and empty come straight from flops.
// ----------------------------------------------------------------------------
module cs_fifo #(
    parameter int WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    logic             r_head_vld, n_head_vld;
    logic             r_tail_vld, n_tail_vld;
    logic [WIDTH-1:0] r_head, n_head;
    logic [WIDTH-1:0] r_tail, n_tail;

    assign o_full  = r_tail_vld;
    assign o_empty = !r_head_vld;
    assign o_data  = r_head;

    // Drop the head on pop, then place a pushed item in the first free slot
    always_comb begin
        n_head_vld = r_head_vld;
        n_tail_vld = r_tail_vld;
        n_head     = r_head;
        n_tail     = r_tail;
        if (i_pop && r_head_vld) begin
            if (r_tail_vld) begin
                n_head     = r_tail;
                n_tail_vld = 1'b0;
            end else begin
                n_head_vld = 1'b0;
            end
        end
        if (i_push && !r_tail_vld) begin
            if (!n_head_vld) begin
                n_head     = i_data;
                n_head_vld = 1'b1;
            end else begin
                n_tail     = i_data;
                n_tail_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= 1'b0;
            r_tail_vld <= 1'b0;
        end else begin
            r_head_vld <= n_head_vld;
            r_tail_vld <= n_tail_vld;
        end
        r_head <= n_head;
        r_tail <= n_tail;
    end

endmodule

FILE: rtl/cs_front.sv
// ----------------------------------------------------------------------------
// Cosine similarity front end
// Accumulates dot product and squared magnitudes, one pair per cycle while
// accepted, and on the last pair hands the final sums to the back end.
// ----------------------------------------------------------------------------
module cs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  cs_pkg::t_item i_item,
    output logic          o_push,
    output cs_pkg::t_sums o_sums
);
    import cs_pkg::*;

    logic signed [DOT_W-1:0] r_dot, n_dot;
    logic [SQ_W-1:0]         r_sqa, n_sqa;
    logic [SQ_W-1:0]         r_sqb, n_sqb;

    logic signed [ELEM_W-1:0]   w_a;
    logic signed [ELEM_W-1:0]   w_b;
    logic signed [2*ELEM_W-1:0] w_ab;
    logic signed [2*ELEM_W-1:0] w_aa;
    logic signed [2*ELEM_W-1:0] w_bb;
    logic signed [DOT_W:0]      w_dot_ext;
    logic [SQ_W:0]              w_sqa_ext;
    logic [SQ_W:0]              w_sqb_ext;

    assign w_a  = i_item.elem_a;
    assign w_b  = i_item.elem_b;
    assign w_ab = w_a * w_b;
    assign w_aa = w_a * w_a;
    assign w_bb = w_b * w_b;

    // Add with one guard bit, then clamp to the sum widths
    assign w_dot_ext = {r_dot[DOT_W-1], r_dot} + (DOT_W+1)'(w_ab);
    assign w_sqa_ext = {1'b0, r_sqa} + (SQ_W+1)'(w_aa[2*ELEM_W-2:0]);
    assign w_sqb_ext = {1'b0, r_sqb} + (SQ_W+1)'(w_bb[2*ELEM_W-2:0]);

    always_comb begin
        if (w_dot_ext[DOT_W] != w_dot_ext[DOT_W-1]) begin
            n_dot = w_dot_ext[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
                                     : {1'b0, {(DOT_W-1){1'b1}}};
        end else begin
            n_dot = w_dot_ext[DOT_W-1:0];
        end
        n_sqa = w_sqa_ext[SQ_W] ? {SQ_W{1'b1}} : w_sqa_ext[SQ_W-1:0];
        n_sqb = w_sqb_ext[SQ_W] ? {SQ_W{1'b1}} : w_sqb_ext[SQ_W-1:0];
    end

    // Hand the finished sums on with the last pair
    assign o_push          = i_accept && i_item.last;
    assign o_sums.dot_sum  = n_dot;
    assign o_sums.sum_sq_a = n_sqa;
    assign o_sums.sum_sq_b = n_sqb;

    // Advance the sums; clear them after the last pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_sqa <= '0;
            r_sqb <= '0;
        end else if (i_accept) begin
            if (i_item.last) begin
                r_dot <= '0;
                r_sqa <= '0;
                r_sqb <= '0;
            end else begin
                r_dot <= n_dot;
                r_sqa <= n_sqa;
                r_sqb <= n_sqb;
            end
        end
    end

endmodule

FILE: rtl/cs_back.sv
// ----------------------------------------------------------------------------
// Cosine similarity back end
// Sequencer around one 21x21 multiplier, a shift-subtract divider and a
// bitwise square root: q = isqrt(floor(dot^2 * 2^30 / (|a|^2 * |b|^2))).
// ----------------------------------------------------------------------------
module cs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    output logic            o_pop,
    input  cs_pkg::t_sums   i_sums,
    input  logic            i_full,
    output logic            o_push,
    output cs_pkg::t_result o_result
);
    import cs_pkg::*;

    localparam int HALF_W = 21;
    localparam int MAG_W  = DOT_W;
    localparam int ACC_W  = 2 * MAG_W;
    localparam int QUO_W  = 31;
    localparam int ROOT_W = ELEM_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DINIT = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SQRT  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [4:0] MUL_LAST  = 5'd8;
    localparam logic [4:0] DIV_LAST  = 5'(QUO_W - 1);
    localparam logic [4:0] SQRT_TOP  = 5'(ROOT_W - 1);
    localparam logic [ELEM_W:0] LIM_POS = (ELEM_W+1)'(32767);
    localparam logic [ELEM_W:0] LIM_NEG = (ELEM_W+1)'(32768);

    logic [2:0]          r_state, n_state;
    logic [4:0]          r_cnt, n_cnt;
    logic                r_neg, n_neg;
    logic                r_zero, n_zero;
    logic [MAG_W-1:0]    r_mag, n_mag;
    logic [SQ_W-1:0]     r_sqa, n_sqa;
    logic [SQ_W-1:0]     r_sqb, n_sqb;
    logic [2*HALF_W-1:0] r_pp, n_pp;
    logic [ACC_W-1:0]    r_prod, n_prod;
    logic [ACC_W-1:0]    r_sq, n_sq;
    logic [ACC_W-2:0]    r_rem, n_rem;
    logic [QUO_W-1:0]    r_quo, n_quo;
    logic [ROOT_W-1:0]   r_root, n_root;

    logic [MAG_W-1:0]    w_x, w_y;
    logic [HALF_W-1:0]   w_xs, w_ys;
    logic [4:0]          w_km1;
    logic [ACC_W-1:0]    w_pp_sh;
    logic [ACC_W-2:0]    w_trial;
    logic [ROOT_W-1:0]   w_t;
    logic [2*ROOT_W-1:0] w_tt;
    logic [ELEM_W:0]     w_lim;
    logic [ELEM_W:0]     w_q;
    logic [ELEM_W:0]     w_qs;

    // Partial product operands: squares of |dot| in the upper phases
    assign w_x   = r_cnt[2] ? r_mag : MAG_W'(r_sqa);
    assign w_y   = r_cnt[2] ? r_mag : MAG_W'(r_sqb);
    assign w_xs  = r_cnt[0] ? w_x[MAG_W-1:HALF_W] : w_x[HALF_W-1:0];
    assign w_ys  = r_cnt[1] ? w_y[MAG_W-1:HALF_W] : w_y[HALF_W-1:0];
    assign w_km1 = r_cnt - 5'd1;

    // Align the registered partial product of the previous phase
    always_comb begin
        case (w_km1[1:0])
            2'd0:    w_pp_sh = ACC_W'(r_pp);
            2'd1:    w_pp_sh = ACC_W'(r_pp) << HALF_W;
            2'd2:    w_pp_sh = ACC_W'(r_pp) << HALF_W;
            default: w_pp_sh = ACC_W'(r_pp) << (2 * HALF_W);
        endcase
    end

    assign w_trial = {r_rem[ACC_W-3:0], (r_cnt == 5'd0) ? r_sq[0] : 1'b0};
    assign w_t     = r_root | (ROOT_W'(1) << r_cnt[3:0]);
    assign w_tt    = w_t * w_t;

    // Clamp to the Q1.15 range for the sign
    assign w_lim = r_neg ? LIM_NEG : LIM_POS;
    assign w_q   = {1'b0, r_root};
    assign w_qs  = (w_q > w_lim) ? w_lim : w_q;

    always_comb begin
        o_result.similarity     = r_zero ? '0
                                : (r_neg ? ELEM_W'(-w_qs) : w_qs[ELEM_W-1:0]);
        o_result.zero_magnitude = r_zero;
    end

    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign o_push = (r_state == S_DONE) && !i_full;

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_zero  = r_zero;
        n_mag   = r_mag;
        n_sqa   = r_sqa;
        n_sqb   = r_sqb;
        n_pp    = r_pp;
        n_prod  = r_prod;
        n_sq    = r_sq;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_root  = r_root;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_sqa  = i_sums.sum_sq_a;
                    n_sqb  = i_sums.sum_sq_b;
                    n_neg  = i_sums.dot_sum[DOT_W-1];
                    n_mag  = i_sums.dot_sum[DOT_W-1] ? MAG_W'(-i_sums.dot_sum)
                                                     : MAG_W'(i_sums.dot_sum);
                    n_zero = (i_sums.sum_sq_a == '0) || (i_sums.sum_sq_b == '0);
                    n_prod = '0;
                    n_sq   = '0;
                    n_cnt  = '0;
                    n_state = n_zero ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                // Multiply this phase, accumulate the previous one
                n_pp = w_xs * w_ys;
                if (r_cnt != 5'd0) begin
                    if (w_km1[2]) begin
                        n_sq = r_sq + w_pp_sh;
                    end else begin
                        n_prod = r_prod + w_pp_sh;
                    end
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == MUL_LAST) begin
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                // Quotient of 2^31 or more saturates the result
                n_rem = r_sq[ACC_W-1:1];
                n_quo = '0;
                n_cnt = '0;
                if (r_sq[ACC_W-1:1] >= r_prod[ACC_W-2:0]) begin
                    n_root  = '1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // One quotient bit per cycle
                if (w_trial >= r_prod[ACC_W-2:0]) begin
                    n_rem = w_trial - r_prod[ACC_W-2:0];
                    n_quo = {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = w_trial;
                    n_quo = {r_quo[QUO_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) begin
                    n_root  = '0;
                    n_cnt   = SQRT_TOP;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                // One root bit per cycle, from the top
                if (w_tt <= {1'b0, r_quo}) begin
                    n_root = w_t;
                end
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_neg  <= n_neg;
        r_zero <= n_zero;
        r_mag  <= n_mag;
        r_sqa  <= n_sqa;
        r_sqb  <= n_sqb;
        r_pp   <= n_pp;
        r_prod <= n_prod;
        r_sq   <= n_sq;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_root <= n_root;
    end

endmodule

FILE: rtl/cosine_similarity.sv
// ----------------------------------------------------------------------------
// Cosine similarity
// Streams paired Q1.15 elements and gives dot / (|a| * |b|) per vector pair.
// ----------------------------------------------------------------------------
//  channel   ports                       handshake
//  item      push, full, i_item          taken when push && !full
//  result    empty, pop, o_result        taken when pop && !empty
//
//  Element pairs enter at one per cycle while full is low; the front sums them
//  at once. Each vector pair then goes through multiply phases on the shared
//  21x21 multiplier, 31 divider steps, 16 root steps and handoff, and a
//  zero-magnitude pair straight to handoff. A two-entry queue of sums lets the
//  next vector stream in meanwhile; full rises only when that queue holds two.
//  Synchronous active-low reset clears the sums, the queues and the sequencer.
// ----------------------------------------------------------------------------
module cosine_similarity (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    input  cs_pkg::t_item   i_item,
    output logic            full,
    output logic            empty,
    input  logic            pop,
    output cs_pkg::t_result o_result
);
    import cs_pkg::*;

    logic    w_accept;
    logic    w_sum_push;
    t_sums   w_sum_in;
    t_sums   w_sum_out;
    logic    w_sum_full;
    logic    w_sum_empty;
    logic    w_sum_pop;
    logic    w_res_push;
    logic    w_res_full;
    t_result w_res_in;

    assign full     = w_sum_full;
    assign w_accept = push && !w_sum_full;

    cs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .o_push   (w_sum_push),
        .o_sums   (w_sum_in)
    );

    cs_fifo #(
        .WIDTH ($bits(t_sums))
    ) u_sum_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_sum_push),
        .i_data  (w_sum_in),
        .o_full  (w_sum_full),
        .o_empty (w_sum_empty),
        .i_pop   (w_sum_pop),
        .o_data  (w_sum_out)
    );

    cs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_sum_empty),
        .o_pop    (w_sum_pop),
        .i_sums   (w_sum_out),
        .i_full   (w_res_full),
        .o_push   (w_res_push),
        .o_result (w_res_in)
    );

    cs_fifo #(
        .WIDTH ($bits(t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (o_result)
    );

endmodule

FILE: rtl/cs_checker.sv
// ----------------------------------------------------------------------------
// Cosine similarity port checker
// Watches the top-level ports over time and binds to the top level.
// ----------------------------------------------------------------------------
module cs_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            full,
    input logic            empty,
    input logic            pop,
    input cs_pkg::t_result o_result
);

    // Reset leaves both sides open and nothing to take
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not clear after reset");

    // A zero-magnitude result carries a zero similarity
    a_zero_sim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.zero_magnitude) |-> (o_result.similarity == '0))
        else $error("zero magnitude with nonzero similarity");

    // A waiting result holds until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("result changed while stalled");

    // A result needs work in the back end, so none shows right after reset
    a_no_early: assert property (@(posedge i_clk)
        !i_rst_n |=> ##1 empty)
        else $error("result appeared too soon after reset");

endmodule

bind cosine_similarity cs_checker u_cs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

FILE: bench/tb_cosine_similarity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine similarity testbench
// Streams element pairs into the block through its push/full side and drains
// results through empty/pop, with random idle bursts on both sides, one long
// receive hold-off that backs up the input, and two pauses that let the block
// run dry. A bit-exact predictor tracks the running sums and works out the
// Q1.15 similarity of every finished vector pair; each popped result is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_cosine_similarity;

    import cs_pkg::*;

    localparam int     CLK_HALF     = 6;
    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     TAIL_ITEMS   = 60;
    localparam int     RANDOM_ITEMS = 425;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     HOLD_AFTER   = 20;
    localparam int     DRAIN_CYCLES = 80;
    localparam longint DOT_MAX      = (longint'(1) <<< (DOT_W - 1)) - 1;
    localparam longint DOT_MIN      = -DOT_MAX - 1;
    localparam longint SQ_MAX       = (longint'(1) <<< SQ_W) - 1;

    // Vector shapes for the random part
    typedef enum int {
        VEC_FULL_RANGE,
        VEC_TINY,
        VEC_ZERO_A,
        VEC_ZERO_B,
        VEC_SAME,
        VEC_NEGATED,
        VEC_EXTREMES
    } t_vec_shape;

    // One element pair to send, optionally held back until the block is empty
    typedef struct {
        t_item pair;
        bit    wait_drain;
    } t_stim;

    logic    i_clk;
    logic    i_rst_n;
    logic    push;
    t_item   i_item;
    logic    full;
    logic    empty;
    logic    pop;
    t_result o_result;

    t_stim   pair_queue[$];
    t_result expected_sims[$];

    // Running sums of the predictor
    logic signed [DOT_W-1:0] dot_acc;
    logic [SQ_W-1:0]         sq_a_acc;
    logic [SQ_W-1:0]         sq_b_acc;

    int n_errors;
    int results_seen;
    int cycle_count;
    int tx_gap;
    int rx_gap;
    int rx_hold;
    bit hold_done;

    cosine_similarity u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // Clock
    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Similarity of finished sums: largest q with q^2 * |a|^2 * |b|^2 <= dot^2 * 2^30
    function automatic t_result similarity_of(logic signed [DOT_W-1:0] dot,
                                              logic [SQ_W-1:0] sq_a,
                                              logic [SQ_W-1:0] sq_b);
        t_result      r;
        logic [127:0] mag;
        logic [127:0] prod;
        logic [127:0] num;
        logic [127:0] trial;
        int unsigned  q;
        int unsigned  t;
        int unsigned  limit;
        bit           neg;
        r = '0;
        if (sq_a == '0 || sq_b == '0) begin
            r.zero_magnitude = 1'b1;
            return r;
        end
        neg   = dot < 0;
        mag   = neg ? 128'(-longint'(dot)) : 128'(longint'(dot));
        prod  = 128'(sq_a) * 128'(sq_b);
        num   = (mag * mag) << 30;
        q     = 0;
        for (int k = 15; k >= 0; k--) begin
            t     = q | (32'd1 << k);
            trial = 128'(t);
            if (prod * trial * trial <= num) begin
                q = t;
            end
        end
        limit = neg ? 32768 : 32767;
        if (q > limit) begin
            q = limit;
        end
        r.similarity = 16'(neg ? -int'(q) : int'(q));
        return r;
    endfunction

    // Add one accepted pair to the sums; close the vector on last
    task automatic accumulate_pair(t_item p);
        longint next_dot;
        longint next_a;
        longint next_b;
        next_dot = longint'(dot_acc) + longint'($signed(p.elem_a)) * longint'($signed(p.elem_b));
        next_a   = longint'(sq_a_acc) + longint'($signed(p.elem_a)) * longint'($signed(p.elem_a));
        next_b   = longint'(sq_b_acc) + longint'($signed(p.elem_b)) * longint'($signed(p.elem_b));
        if (next_dot > DOT_MAX) next_dot = DOT_MAX;
        if (next_dot < DOT_MIN) next_dot = DOT_MIN;
        if (next_a > SQ_MAX) next_a = SQ_MAX;
        if (next_b > SQ_MAX) next_b = SQ_MAX;
        dot_acc  = DOT_W'(next_dot);
        sq_a_acc = SQ_W'(next_a);
        sq_b_acc = SQ_W'(next_b);
        if (p.last) begin
            expected_sims = {expected_sims, similarity_of(dot_acc, sq_a_acc, sq_b_acc)};
            dot_acc  = '0;
            sq_a_acc = '0;
            sq_b_acc = '0;
        end
    endtask

    task automatic queue_pair(logic [15:0] a, logic [15:0] b, logic last, bit wait_drain);
        t_stim s;
        s.pair.elem_a = a;
        s.pair.elem_b = b;
        s.pair.last   = last;
        s.wait_drain  = wait_drain;
        pair_queue = {pair_queue, s};
    endtask

    // Queue one random vector pair; returns its length
    task automatic queue_random_vector(bit wait_drain, output int len);
        t_vec_shape  shape;
        logic [15:0] ea;
        logic [15:0] eb;
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        shape = t_vec_shape'($urandom_range(0, 9) > 6 ? 0 : $urandom_range(0, 6));
        for (int k = 0; k < len; k++) begin
            ea = 16'($urandom);
            eb = 16'($urandom);
            case (shape)
                VEC_TINY: begin
                    ea = 16'($urandom_range(0, 15)) - 16'd8;
                    eb = 16'($urandom_range(0, 15)) - 16'd8;
                end
                VEC_ZERO_A:   ea = '0;
                VEC_ZERO_B:   eb = '0;
                VEC_SAME:     eb = ea;
                VEC_NEGATED:  eb = -ea;
                VEC_EXTREMES: begin
                    ea = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                    eb = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                end
                default: ;
            endcase
            queue_pair(ea, eb, k == len - 1, wait_drain && k == 0);
        end
    endtask

    // Driver: present queued pairs, retire accepted ones into the predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push   <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (push && !full) begin
                accumulate_pair(i_item);
            end
            if (push && full) begin
                // hold the offered item
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                push   <= 1'b0;
            end else if (pair_queue.size() == 0) begin
                push <= 1'b0;
            end else if (pair_queue[0].wait_drain && expected_sims.size() != 0) begin
                push <= 1'b0;
            end else if (pair_queue.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                tx_gap <= $urandom_range(1, 5) - 1;
                push   <= 1'b0;
            end else begin
                i_item <= pair_queue[0].pair;
                pair_queue.pop_front();
                push   <= 1'b1;
            end
        end
    end

    // Monitor: check popped results, stall the result side at random
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            pop     <= 1'b0;
            rx_gap  <= 0;
            rx_hold <= 0;
        end else begin
            if (pop && !empty) begin
                results_seen <= results_seen + 1;
                if (expected_sims.size() == 0) begin
                    $error("unexpected result: similarity %0d zero_magnitude %0b",
                           o_result.similarity, o_result.zero_magnitude);
                    n_errors = n_errors + 1;
                end else begin
                    exp_r = expected_sims.pop_front();
                    if (o_result.similarity !== exp_r.similarity) begin
                        $error("similarity: expected %0d, got %0d",
                               exp_r.similarity, o_result.similarity);
                        n_errors = n_errors + 1;
                    end
                    if (o_result.zero_magnitude !== exp_r.zero_magnitude) begin
                        $error("zero_magnitude: expected %0b, got %0b",
                               exp_r.zero_magnitude, o_result.zero_magnitude);
                        n_errors = n_errors + 1;
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                pop     <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                // long hold-off: let the block back up and assert full
                hold_done <= 1'b1;
                rx_hold   <= HOLD_CYCLES - 1;
                pop       <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                pop    <= 1'b0;
            end else if (pair_queue.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                rx_gap <= $urandom_range(1, 5) - 1;
                pop    <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_cosine_similarity: FAIL");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        int random_items;
        int vec_count;
        int len;
        i_rst_n      = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        i_item       = '0;
        n_errors     = 0;
        results_seen = 0;
        cycle_count  = 0;
        hold_done    = 1'b0;
        dot_acc      = '0;
        sq_a_acc     = '0;
        sq_b_acc     = '0;

        // full-scale single pairs, both signs, saturating to +1 and -1
        queue_pair(16'h7FFF, 16'h7FFF, 1'b1, 1'b0);
        queue_pair(16'h8000, 16'h8000, 1'b1, 1'b0);
        queue_pair(16'h8000, 16'h7FFF, 1'b1, 1'b0);
        queue_pair(16'h7FFF, 16'h8000, 1'b1, 1'b0);
        // zero magnitude on a, on b, on both
        queue_pair(16'd0, 16'd1234, 1'b1, 1'b0);
        queue_pair(-16'd5, 16'd0, 1'b1, 1'b0);
        queue_pair(16'd0, 16'd0, 1'b1, 1'b0);
        // orthogonal vectors: zero dot, nonzero magnitudes
        queue_pair(16'd1, 16'd0, 1'b0, 1'b0);
        queue_pair(16'd0, 16'd1, 1'b1, 1'b0);
        // tiny values
        queue_pair(16'd1, 16'd1, 1'b0, 1'b0);
        queue_pair(-16'd1, 16'd1, 1'b0, 1'b0);
        queue_pair(16'd2, -16'd3, 1'b1, 1'b0);
        // zero pairs inside a vector
        queue_pair(16'd0, 16'd0, 1'b0, 1'b0);
        queue_pair(16'd100, -16'd200, 1'b0, 1'b0);
        queue_pair(16'd0, 16'd0, 1'b1, 1'b0);
        queue_pair(16'd0, 16'd0, 1'b0, 1'b0);
        queue_pair(16'd0, 16'd0, 1'b0, 1'b0);
        queue_pair(16'd7, 16'd0, 1'b1, 1'b0);
        // mixed magnitudes
        queue_pair(16'd12345, -16'd23456, 1'b0, 1'b0);
        queue_pair(16'h8000, 16'h7FFF, 1'b0, 1'b0);
        queue_pair(16'h7FFF, 16'd1, 1'b1, 1'b0);

        // random vectors; pause for a full drain at the start and midway
        random_items = 0;
        vec_count    = 0;
        while (random_items < RANDOM_ITEMS) begin
            queue_random_vector(vec_count == 0 || vec_count == 40, len);
            random_items += len;
            vec_count++;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pair_queue.size() != 0 || push || expected_sims.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && expected_sims.size() == 0) begin
            $display("tb_cosine_similarity: PASS");
        end else begin
            $display("tb_cosine_similarity: FAIL");
        end
        $finish;
    end

endmodule
